// ----- rtl/core/lqs_pkg.sv -----
// shared types and constants of the link quality statistics block
`default_nettype none
package lqs_pkg;

	// event command codes
	typedef enum logic [1:0] {
		CMD_SENT  = 2'd0,
		CMD_RTT   = 2'd1,
		CMD_RX    = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_JDIFF,
		ST_JADD,
		ST_AVG_SETUP,
		ST_LOSS_SUB,
		ST_LOSS_MUL,
		ST_DIV,
		ST_DIV_END,
		ST_OUT
	} state_t;

	// divider operation, selects where the quotient lands
	typedef enum logic {
		DIV_AVG,
		DIV_LOSS
	} div_op_t;

	localparam int unsigned JIT_SHIFT      = 4;
	localparam logic [9:0]  PER_MILLE      = 10'd1000;
	localparam int unsigned DIV_WIDTH      = 64;
	localparam int unsigned LOSS_PROD_W    = 42;
	localparam int unsigned LOSS_ALIGN     = DIV_WIDTH - LOSS_PROD_W;
	localparam int unsigned DIV_CNT_W      = $clog2(DIV_WIDTH + 1);
	localparam logic [DIV_CNT_W-1:0] DIV_AVG_STEPS  = DIV_CNT_W'(DIV_WIDTH);
	localparam logic [DIV_CNT_W-1:0] DIV_LOSS_STEPS = DIV_CNT_W'(LOSS_PROD_W);

endpackage
`default_nettype wire

// ----- rtl/core/link_quality_statistics.sv -----
// link quality statistics: counters, rtt min/max/average, jitter and loss figure
//
// usage
//  - input channel in_valid/in_ready carries one link event per transaction:
//    command selects sent event, rtt sample, rx count add or clear all
//  - output channel out_valid/out_ready returns one transaction per event with
//    all totals and the derived figures, taken after the event is applied
//  - one event at a time through a small sequencer
//    rtt sample: jitter update (skipped on the first sample), then a 64-step
//    radix-2 divide for the average; sent and rx events: a 42-step divide for
//    the loss figure, skipped when nothing is lost; clear: straight to output
//    the shared restoring divider produces one quotient bit per cycle
//  - average and loss are cached and recomputed only when their inputs change
//  - in_ready is high only while the sequencer is idle
//  - results sit in an output register; a new event is taken while an earlier
//    result waits, and its result is held back until the register frees up
//  - reset (arst_n low, asynchronous) clears all counters, sets the rtt
//    minimum to all ones and drops any pending result
`default_nettype none
module link_quality_statistics
	import lqs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// event channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic        send_ok,
	input  wire logic [31:0] rtt_sample,
	input  wire logic [31:0] rx_delivered,
	input  wire logic [31:0] rx_duplicates,
	input  wire logic [31:0] rx_stale,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      sent_total,
	output logic [31:0]      failed_total,
	output logic [31:0]      received_total,
	output logic [31:0]      duplicate_total,
	output logic [31:0]      stale_total,
	output logic [31:0]      rtt_minimum,
	output logic [31:0]      rtt_maximum,
	output logic [31:0]      rtt_average,
	output logic [31:0]      jitter_estimate,
	output logic [9:0]       loss_per_mille,
	output logic [31:0]      rtt_samples
);

	// sequencer
	state_t state_q, state_d;

	// captured event (payload, no reset)
	cmd_t        cmd_q;
	logic        ok_q;
	logic [31:0] rtt_q;
	logic [31:0] dlv_q;
	logic [31:0] dup_q;
	logic [31:0] stl_q;

	// statistics state
	logic [31:0] sent_cnt_q;
	logic [31:0] fail_cnt_q;
	logic [31:0] recv_cnt_q;
	logic [31:0] dup_cnt_q;
	logic [31:0] stale_cnt_q;
	logic [31:0] min_rtt_q;
	logic [31:0] max_rtt_q;
	logic [31:0] last_rtt_q;
	logic [63:0] rtt_sum_q;
	logic [31:0] sample_cnt_q;
	logic [31:0] jitter_q;
	logic [31:0] avg_q;
	logic [9:0]  loss_q;
	logic        out_valid_q;

	// scratch registers for jitter and loss
	logic [31:0] absd_q;
	logic        jgt_q;
	logic [31:0] jdiff_q;
	logic [31:0] ldiff_q;

	// shared divider
	div_op_t              div_op_q;
	logic [63:0]          num_q;
	logic [31:0]          den_q;
	logic [31:0]          rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [32:0] rem_shift;
	logic        div_ge;
	logic [32:0] rem_sub;
	logic [31:0] rem_next;
	logic [63:0] num_next;

	// controls from the sequencer
	logic in_take;
	logic out_load;
	logic loss_zero;
	logic [LOSS_PROD_W-1:0] loss_prod;

	// one restoring divide step: shift in the next dividend bit, subtract if it fits
	assign rem_shift = {rem_q, num_q[DIV_WIDTH-1]};
	assign div_ge    = rem_shift >= {1'b0, den_q};
	assign rem_sub   = rem_shift - {1'b0, den_q};
	assign rem_next  = div_ge ? rem_sub[31:0] : rem_shift[31:0];
	assign num_next  = {num_q[DIV_WIDTH-2:0], div_ge};

	// loss figure is zero when nothing was sent or nothing is missing
	assign loss_zero = (sent_cnt_q == 32'd0) || (recv_cnt_q >= sent_cnt_q);
	assign loss_prod = LOSS_PROD_W'(ldiff_q) * LOSS_PROD_W'(PER_MILLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				unique case (cmd_q)
					CMD_SENT, CMD_RX: state_d = ST_LOSS_SUB;
					CMD_RTT: begin
						// first sample skips the jitter update
						state_d = (sample_cnt_q != 32'd0) ? ST_JDIFF : ST_AVG_SETUP;
					end
					CMD_CLEAR: state_d = ST_OUT;
					default: state_d = ST_OUT;
				endcase
			end
			ST_JDIFF:     state_d = ST_JADD;
			ST_JADD:      state_d = ST_AVG_SETUP;
			ST_AVG_SETUP: state_d = (sample_cnt_q != 32'd0) ? ST_DIV : ST_OUT;
			ST_LOSS_SUB:  state_d = loss_zero ? ST_OUT : ST_LOSS_MUL;
			ST_LOSS_MUL:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_CNT_W'(1)) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END:   state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_OUT:  out_load = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	assign in_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// event capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q <= cmd_t'(command);
			ok_q  <= send_ok;
			rtt_q <= rtt_sample;
			dlv_q <= rx_delivered;
			dup_q <= rx_duplicates;
			stl_q <= rx_stale;
		end
	end

	// statistics state and cached figures
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_cnt_q   <= '0;
			fail_cnt_q   <= '0;
			recv_cnt_q   <= '0;
			dup_cnt_q    <= '0;
			stale_cnt_q  <= '0;
			min_rtt_q    <= '1;
			max_rtt_q    <= '0;
			last_rtt_q   <= '0;
			rtt_sum_q    <= '0;
			sample_cnt_q <= '0;
			jitter_q     <= '0;
			avg_q        <= '0;
			loss_q       <= '0;
		end else begin
			case (state_q)
				ST_UPDATE: begin
					case (cmd_q)
						CMD_SENT: begin
							sent_cnt_q <= sent_cnt_q + 32'd1;
							if (!ok_q) begin
								fail_cnt_q <= fail_cnt_q + 32'd1;
							end
						end
						CMD_RTT: begin
							if (rtt_q < min_rtt_q) begin
								min_rtt_q <= rtt_q;
							end
							if (rtt_q > max_rtt_q) begin
								max_rtt_q <= rtt_q;
							end
							last_rtt_q   <= rtt_q;
							rtt_sum_q    <= rtt_sum_q + 64'(rtt_q);
							sample_cnt_q <= sample_cnt_q + 32'd1;
						end
						CMD_RX: begin
							recv_cnt_q  <= recv_cnt_q + dlv_q;
							dup_cnt_q   <= dup_cnt_q + dup_q;
							stale_cnt_q <= stale_cnt_q + stl_q;
						end
						default: begin
							// clear all
							sent_cnt_q   <= '0;
							fail_cnt_q   <= '0;
							recv_cnt_q   <= '0;
							dup_cnt_q    <= '0;
							stale_cnt_q  <= '0;
							min_rtt_q    <= '1;
							max_rtt_q    <= '0;
							last_rtt_q   <= '0;
							rtt_sum_q    <= '0;
							sample_cnt_q <= '0;
							jitter_q     <= '0;
							avg_q        <= '0;
							loss_q       <= '0;
						end
					endcase
				end
				ST_JADD: begin
					// j += (|d| - j) >> 4, in unsigned form
					if (jgt_q) begin
						jitter_q <= jitter_q + (jdiff_q >> JIT_SHIFT);
					end else begin
						jitter_q <= jitter_q - (jdiff_q >> JIT_SHIFT);
					end
				end
				ST_AVG_SETUP: begin
					if (sample_cnt_q == 32'd0) begin
						avg_q <= '0;
					end
				end
				ST_LOSS_SUB: begin
					if (loss_zero) begin
						loss_q <= '0;
					end
				end
				ST_DIV_END: begin
					if (div_op_q == DIV_AVG) begin
						avg_q <= num_q[31:0];
					end else begin
						loss_q <= num_q[9:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// jitter and loss scratch, divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_UPDATE: begin
				// |d| against the previous sample
				absd_q <= (rtt_q > last_rtt_q) ? (rtt_q - last_rtt_q) : (last_rtt_q - rtt_q);
			end
			ST_JDIFF: begin
				jgt_q   <= absd_q > jitter_q;
				jdiff_q <= (absd_q > jitter_q) ? (absd_q - jitter_q) : (jitter_q - absd_q);
			end
			ST_AVG_SETUP: begin
				div_op_q <= DIV_AVG;
				num_q    <= rtt_sum_q;
				den_q    <= sample_cnt_q;
				rem_q    <= '0;
				cnt_q    <= DIV_AVG_STEPS;
			end
			ST_LOSS_SUB: begin
				ldiff_q <= sent_cnt_q - recv_cnt_q;
			end
			ST_LOSS_MUL: begin
				// product sits at the top so only its bits are stepped through
				div_op_q <= DIV_LOSS;
				num_q    <= {loss_prod, LOSS_ALIGN'(0)};
				den_q    <= sent_cnt_q;
				rem_q    <= '0;
				cnt_q    <= DIV_LOSS_STEPS;
			end
			ST_DIV: begin
				num_q <= num_next;
				rem_q <= rem_next;
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sent_total      <= sent_cnt_q;
			failed_total    <= fail_cnt_q;
			received_total  <= recv_cnt_q;
			duplicate_total <= dup_cnt_q;
			stale_total     <= stale_cnt_q;
			rtt_minimum     <= (sample_cnt_q != 32'd0) ? min_rtt_q : 32'd0;
			rtt_maximum     <= max_rtt_q;
			rtt_average     <= avg_q;
			jitter_estimate <= jitter_q;
			loss_per_mille  <= loss_q;
			rtt_samples     <= sample_cnt_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- tb/link_quality_statistics_checker.sv -----
`timescale 1ns / 100ps
// checker: predicts every link statistics result and compares it with the block
module link_quality_statistics_checker
	import lqs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic        send_ok,
	input  logic [31:0] rtt_sample,
	input  logic [31:0] rx_delivered,
	input  logic [31:0] rx_duplicates,
	input  logic [31:0] rx_stale,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] sent_total,
	input  logic [31:0] failed_total,
	input  logic [31:0] received_total,
	input  logic [31:0] duplicate_total,
	input  logic [31:0] stale_total,
	input  logic [31:0] rtt_minimum,
	input  logic [31:0] rtt_maximum,
	input  logic [31:0] rtt_average,
	input  logic [31:0] jitter_estimate,
	input  logic [9:0]  loss_per_mille,
	input  logic [31:0] rtt_samples,
	output int unsigned fail_count,
	output int unsigned outstanding
);

	typedef struct {
		logic [31:0] sent;
		logic [31:0] failed;
		logic [31:0] received;
		logic [31:0] duplicate;
		logic [31:0] stale;
		logic [31:0] rmin;
		logic [31:0] rmax;
		logic [31:0] ravg;
		logic [31:0] jitter;
		logic [9:0]  loss;
		logic [31:0] samples;
	} link_stats_t;

	// predicted state of the block
	logic [31:0] sends;
	logic [31:0] send_fails;
	logic [31:0] delivered;
	logic [31:0] duplicates;
	logic [31:0] stales;
	logic [31:0] rtt_low;
	logic [31:0] rtt_high;
	logic [31:0] rtt_prev;
	logic [63:0] rtt_acc;
	logic [31:0] rtt_taken;
	logic [31:0] jitter_acc;

	link_stats_t pending_stats[$];

	task automatic report(input string what);
		fail_count++;
		$display("%0t ns: link stats mismatch, %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s is %0h, %0h predicted", name, got, want));
	endtask

	task automatic clear_stats();
		sends      = '0;
		send_fails = '0;
		delivered  = '0;
		duplicates = '0;
		stales     = '0;
		rtt_low    = '1;
		rtt_high   = '0;
		rtt_prev   = '0;
		rtt_acc    = '0;
		rtt_taken  = '0;
		jitter_acc = '0;
	endtask

	// min/max/sum/count plus the smoothed jitter, skipped on the first sample
	task automatic add_rtt(input logic [31:0] r);
		logic [31:0] gap;
		if (rtt_taken != 0) begin
			gap = (r > rtt_prev) ? r - rtt_prev : rtt_prev - r;
			if (gap > jitter_acc)
				jitter_acc = jitter_acc + ((gap - jitter_acc) >> JIT_SHIFT);
			else
				jitter_acc = jitter_acc - ((jitter_acc - gap) >> JIT_SHIFT);
		end
		if (r < rtt_low)
			rtt_low = r;
		if (r > rtt_high)
			rtt_high = r;
		rtt_prev  = r;
		rtt_acc   = rtt_acc + 64'(r);
		rtt_taken = rtt_taken + 32'd1;
	endtask

	function automatic logic [9:0] loss_ratio();
		logic [63:0] lost;
		logic [63:0] ratio;
		if (sends == 0 || delivered >= sends)
			return '0;
		lost  = 64'(sends - delivered) * 64'(PER_MILLE);
		ratio = lost / 64'(sends);
		return ratio[9:0];
	endfunction

	task automatic apply_link_event(input cmd_t op, input logic ok, input logic [31:0] r,
		input logic [31:0] dl, input logic [31:0] du, input logic [31:0] st);
		link_stats_t want;
		logic [63:0] mean;
		case (op)
			CMD_SENT: begin
				sends = sends + 32'd1;
				if (!ok)
					send_fails = send_fails + 32'd1;
			end
			CMD_RTT: add_rtt(r);
			CMD_RX: begin
				delivered  = delivered + dl;
				duplicates = duplicates + du;
				stales     = stales + st;
			end
			default: clear_stats();
		endcase
		mean           = (rtt_taken != 0) ? rtt_acc / 64'(rtt_taken) : '0;
		want.sent      = sends;
		want.failed    = send_fails;
		want.received  = delivered;
		want.duplicate = duplicates;
		want.stale     = stales;
		want.rmin      = (rtt_taken != 0) ? rtt_low : '0;
		want.rmax      = rtt_high;
		want.ravg      = mean[31:0];
		want.jitter    = jitter_acc;
		want.loss      = loss_ratio();
		want.samples   = rtt_taken;
		pending_stats.push_back(want);
	endtask

	initial begin
		fail_count  = 0;
		outstanding = 0;
		clear_stats();
	end

	always @(posedge clk) begin : watch
		link_stats_t want;
		if (!arst_n) begin
			clear_stats();
			pending_stats.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pending_stats.size() == 0) begin
					report("result transaction with no event waiting");
				end else begin
					want = pending_stats.pop_front();
					check_field("sent_total", sent_total, want.sent);
					check_field("failed_total", failed_total, want.failed);
					check_field("received_total", received_total, want.received);
					check_field("duplicate_total", duplicate_total, want.duplicate);
					check_field("stale_total", stale_total, want.stale);
					check_field("rtt_minimum", rtt_minimum, want.rmin);
					check_field("rtt_maximum", rtt_maximum, want.rmax);
					check_field("rtt_average", rtt_average, want.ravg);
					check_field("jitter_estimate", jitter_estimate, want.jitter);
					check_field("loss_per_mille", 32'(loss_per_mille), 32'(want.loss));
					check_field("rtt_samples", rtt_samples, want.samples);
				end
			end
			if (in_valid && in_ready)
				apply_link_event(cmd_t'(command), send_ok, rtt_sample, rx_delivered,
					rx_duplicates, rx_stale);
		end
		outstanding = pending_stats.size();
	end

endmodule

// ----- tb/tb_link_quality_statistics.sv -----
`timescale 1ns / 100ps
// testbench top: link event stimulus, result back-pressure and the final verdict
module tb_link_quality_statistics;
	import lqs_pkg::*;

	localparam int unsigned RANDOM_PER_PHASE = 483;
	localparam int unsigned HOLD_CYCLES      = 400;
	localparam int unsigned END_SLACK        = 100;

	// every input starts at a known value
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	cmd_t        command       = CMD_SENT;
	logic        send_ok       = 1'b0;
	logic [31:0] rtt_sample    = '0;
	logic [31:0] rx_delivered  = '0;
	logic [31:0] rx_duplicates = '0;
	logic [31:0] rx_stale      = '0;
	logic        out_ready     = 1'b0;

	logic        in_ready;
	logic        out_valid;
	logic [31:0] sent_total;
	logic [31:0] failed_total;
	logic [31:0] received_total;
	logic [31:0] duplicate_total;
	logic [31:0] stale_total;
	logic [31:0] rtt_minimum;
	logic [31:0] rtt_maximum;
	logic [31:0] rtt_average;
	logic [31:0] jitter_estimate;
	logic [9:0]  loss_per_mille;
	logic [31:0] rtt_samples;

	int unsigned fail_count;
	int unsigned outstanding;

	// idle and stall odds in percent, changed per phase
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;

	// long receiver hold-off: the stimulus bumps hold_seq, the receiver counts the cycles
	int unsigned hold_seq  = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	link_quality_statistics dut (.*);

	link_quality_statistics_checker stats_check (.*);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver side: random stalls, or a counted hold-off when one is requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// offer one event transaction and wait until the block takes it
	// valid stays high into the next call unless that call idles first
	task automatic drive_event(input cmd_t op, input logic ok, input logic [31:0] rtt,
		input logic [31:0] dlv, input logic [31:0] dup, input logic [31:0] stl);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid   <= 1'b0;
			// junk on the idle bus must be ignored
			rtt_sample <= $urandom;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		command       <= op;
		send_ok       <= ok;
		rtt_sample    <= rtt;
		rx_delivered  <= dlv;
		rx_duplicates <= dup;
		rx_stale      <= stl;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// pause the sender until every predicted result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// one random event; fields the command does not use carry random junk
	task automatic random_event();
		int unsigned pick;
		cmd_t        op;
		logic        ok;
		logic [31:0] rtt;
		logic [31:0] dlv;
		logic [31:0] dup;
		logic [31:0] stl;
		pick = $urandom_range(99);
		ok   = 1'($urandom_range(1));
		rtt  = $urandom;
		dlv  = $urandom;
		dup  = $urandom;
		stl  = $urandom;
		if (pick < 30) begin
			op = CMD_SENT;
		end else if (pick < 62) begin
			op = CMD_RTT;
			// mostly a realistic spread around a few ms, sometimes the extremes
			case ($urandom_range(7))
				0: rtt = $urandom;
				1: rtt = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
				default: rtt = 32'd1000 + $urandom_range(4000);
			endcase
		end else if (pick < 95) begin
			op = CMD_RX;
			// small deliveries keep the loss figure alive, big ones wrap the totals
			if ($urandom_range(9) != 0)
				dlv = $urandom_range(1);
			if ($urandom_range(3) != 0)
				dup = $urandom_range(3);
			if ($urandom_range(3) != 0)
				stl = $urandom_range(3);
		end else begin
			op = CMD_CLEAR;
		end
		drive_event(op, ok, rtt, dlv, dup, stl);
	endtask

	// main stimulus
	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed part: send flag, loss corners, first sample, extremes, wrap, clear
		drive_event(CMD_SENT, 1'b1, '1, '1, '1, '1);
		drive_event(CMD_SENT, 1'b0, '0, '0, '0, '0);
		drive_event(CMD_RX, 1'b1, '1, 32'd1, 32'd0, 32'd0);
		drive_event(CMD_RTT, 1'b1, 32'd0, '1, '1, '1);
		drive_event(CMD_RTT, 1'b0, 32'hFFFF_FFFF, '0, '0, '0);
		drive_event(CMD_RTT, 1'b0, 32'd1000, '0, '0, '0);
		drive_event(CMD_RTT, 1'b0, 32'd1000, '0, '0, '0);
		drive_event(CMD_RX, 1'b0, '0, '1, '1, '1);
		drive_event(CMD_RX, 1'b0, '0, 32'd2, 32'd1, 32'd1);
		drive_event(CMD_SENT, 1'b0, '1, '1, '1, '1);
		drive_event(CMD_CLEAR, 1'b1, '1, '1, '1, '1);
		// sends with nothing received: full loss
		drive_event(CMD_SENT, 1'b1, '0, '0, '0, '0);
		drive_event(CMD_RTT, 1'b0, 32'd5, '1, '1, '1);
		drive_event(CMD_RTT, 1'b0, 32'hFFFF_FFFF, '0, '0, '0);
		drive_event(CMD_RTT, 1'b0, 32'hFFFF_FFFF, '0, '0, '0);
		drive_event(CMD_RX, 1'b0, '0, '0, '0, '0);
		drive_event(CMD_CLEAR, 1'b0, '0, '0, '0, '0);
		// received ahead of sent: no loss
		drive_event(CMD_RX, 1'b0, '0, 32'd5, 32'd0, 32'd0);
		drive_event(CMD_SENT, 1'b1, '0, '0, '0, '0);
		drive_event(CMD_CLEAR, 1'b0, '0, '0, '0, '0);
		wait_drained();

		// random part in idling phases, drained in between
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
					// receiver holds off while the sender keeps offering
					hold_seq <= hold_seq + 1;
				end
				1: begin
					send_idle_pct = 64;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 64;
				end
				default: begin
					send_idle_pct = 6;
					stall_pct     = 6;
				end
			endcase
			repeat (RANDOM_PER_PHASE)
				random_event();
			wait_drained();
		end

		// catch any stray result transaction
		repeat (END_SLACK) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("link_quality_statistics verification clean");
		else
			$display("link_quality_statistics verification failed");
		$finish;
	end

	// deadline, far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("link_quality_statistics verification failed");
		$finish;
	end

endmodule
